// ----- hw/rtl/bog_pkg.sv -----
// Shared types, constants and helpers for the block offset generator.
package bog_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned SIZE_W    = 25;
    localparam int unsigned OFFSET_W  = 56;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [VALUE_W-1:0] SEED_VALUE    = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [VALUE_W-1:0] SCRAMBLE_MULT = 64'h2545_F491_4F6C_DD1D;

    localparam int unsigned SHIFT_A = 12;
    localparam int unsigned SHIFT_B = 25;
    localparam int unsigned SHIFT_C = 27;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 32'd1;
    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 25'd4096;
    localparam logic [SIZE_W-1:0]  MAX_BLOCK_SIZE  = 25'h100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_COUNT = 2'd0,
        REG_BLOCK_SIZE  = 2'd1,
        REG_SEQ_MODE    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic first_of_run;
        logic last_of_run;
    } req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } job_t;

    typedef struct packed {
        logic [COUNT_W-1:0] block_count;
        logic [SIZE_W-1:0]  block_size;
        logic               sequential_mode;
    } cfg_t;

    function automatic logic [VALUE_W-1:0] xorshift_step(input logic [VALUE_W-1:0] x_in);
        logic [VALUE_W-1:0] x;
        x = x_in;
        x = x ^ (x >> SHIFT_A);
        x = x ^ (x << SHIFT_B);
        x = x ^ (x >> SHIFT_C);
        return x;
    endfunction

endpackage

// ----- hw/rtl/bog_front.sv -----
// Front end: accepts requests, keeps generator and counter state, forms the value to reduce.
module bog_front (
    input  logic          clk,
    input  logic          rst_n,
    input  bog_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  bog_pkg::req_t req,
    output logic          push_valid,
    input  logic          push_ready,
    output bog_pkg::job_t push_data
);
    import bog_pkg::*;

    localparam int unsigned BIT_CNT_W = $clog2(COUNT_W);
    localparam int unsigned HALF_W    = VALUE_W / 2;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CHECK,
        F_NORM,
        F_ADV,
        F_STEP,
        F_MUL0,
        F_MUL1,
        F_MUL2
    } fstate_t;

    fstate_t              state_reg;
    logic                 push_pending_reg;
    logic [VALUE_W-1:0]   prng_reg;
    logic [COUNT_W-1:0]   seq_reg;
    logic                 last_reg;
    logic [COUNT_W-1:0]   cur_reg;
    logic [COUNT_W-1:0]   div_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [VALUE_W-1:0]   prod_reg;
    logic [HALF_W-1:0]    hi_reg;
    logic [VALUE_W-1:0]   value_reg;

    logic [COUNT_W:0]     rem_shift;
    logic [COUNT_W-1:0]   rem_next;
    logic [COUNT_W:0]     cur_inc;
    logic [HALF_W-1:0]    mul_a;
    logic [HALF_W-1:0]    mul_b;
    logic [VALUE_W-1:0]   mul_p;

    assign req_ready  = (state_reg == F_IDLE) && !push_pending_reg;
    assign push_valid = push_pending_reg;
    assign push_data  = '{value: value_reg, last: last_reg};

    always_comb
    begin
        rem_shift = {rem_reg, div_reg[COUNT_W-1]};
        if (rem_shift >= {1'b0, cfg.block_count})
        begin
            rem_next = COUNT_W'(rem_shift - {1'b0, cfg.block_count});
        end
        else
        begin
            rem_next = rem_shift[COUNT_W-1:0];
        end
    end

    assign cur_inc = {1'b0, cur_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign mul_a   = (state_reg == F_MUL2) ? prng_reg[VALUE_W-1:HALF_W] : prng_reg[HALF_W-1:0];
    assign mul_b   = (state_reg == F_MUL1) ? SCRAMBLE_MULT[VALUE_W-1:HALF_W]
                                           : SCRAMBLE_MULT[HALF_W-1:0];
    assign mul_p   = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= F_IDLE;
            push_pending_reg <= 1'b0;
            prng_reg         <= SEED_VALUE;
            seq_reg          <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (push_pending_reg)
                    begin
                        if (push_ready)
                        begin
                            push_pending_reg <= 1'b0;
                        end
                    end
                    else if (req_valid)
                    begin
                        last_reg <= req.last_of_run;
                        if (req.first_of_run)
                        begin
                            prng_reg <= SEED_VALUE;
                            seq_reg  <= '0;
                        end
                        state_reg <= F_CHECK;
                    end
                end
                F_CHECK:
                begin
                    if (seq_reg >= cfg.block_count)
                    begin
                        div_reg     <= seq_reg;
                        rem_reg     <= '0;
                        bit_cnt_reg <= '0;
                        state_reg   <= F_NORM;
                    end
                    else
                    begin
                        cur_reg   <= seq_reg;
                        state_reg <= F_ADV;
                    end
                end
                F_NORM:
                begin
                    rem_reg     <= rem_next;
                    div_reg     <= div_reg << 1;
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == BIT_CNT_W'(COUNT_W - 1))
                    begin
                        cur_reg   <= rem_next;
                        state_reg <= F_ADV;
                    end
                end
                F_ADV:
                begin
                    if (cur_inc >= {1'b0, cfg.block_count})
                    begin
                        seq_reg <= '0;
                    end
                    else
                    begin
                        seq_reg <= cur_inc[COUNT_W-1:0];
                    end
                    if (cfg.sequential_mode)
                    begin
                        value_reg        <= {{(VALUE_W-COUNT_W){1'b0}}, cur_reg};
                        push_pending_reg <= 1'b1;
                        state_reg        <= F_IDLE;
                    end
                    else
                    begin
                        state_reg <= F_STEP;
                    end
                end
                F_STEP:
                begin
                    prng_reg  <= xorshift_step(prng_reg);
                    state_reg <= F_MUL0;
                end
                F_MUL0:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= F_MUL1;
                end
                F_MUL1:
                begin
                    hi_reg    <= prod_reg[VALUE_W-1:HALF_W] + mul_p[HALF_W-1:0];
                    state_reg <= F_MUL2;
                end
                F_MUL2:
                begin
                    value_reg        <= {hi_reg + mul_p[HALF_W-1:0], prod_reg[HALF_W-1:0]};
                    push_pending_reg <= 1'b1;
                    state_reg        <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/bog_queue.sv -----
// Small FIFO of pending jobs between front and back.
module bog_queue #(
    parameter int unsigned DEPTH = bog_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  bog_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bog_pkg::job_t pop_data
);
    import bog_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/bog_back.sv -----
// Back end: bit-serial reduction by block count, scaling by block size, output register.
module bog_back (
    input  logic          clk,
    input  logic          rst_n,
    input  bog_pkg::cfg_t cfg,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  bog_pkg::job_t pop_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bog_pkg::rsp_t rsp
);
    import bog_pkg::*;

    localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);

    typedef enum logic [1:0] {
        B_IDLE,
        B_MOD,
        B_MUL,
        B_OUT
    } bstate_t;

    bstate_t              state_reg;
    logic [VALUE_W-1:0]   div_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic                 last_reg;
    logic [OFFSET_W-1:0]  prod_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    logic [COUNT_W:0]         rem_shift;
    logic [COUNT_W-1:0]       rem_next;
    logic [COUNT_W+SIZE_W-1:0] scaled;
    logic                     out_free;
    logic                     out_load;

    assign pop_ready = (state_reg == B_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign out_load  = (state_reg == B_OUT) && out_free;
    assign scaled    = rem_reg * cfg.block_size;

    always_comb
    begin
        rem_shift = {rem_reg, div_reg[VALUE_W-1]};
        if (rem_shift >= {1'b0, cfg.block_count})
        begin
            rem_next = COUNT_W'(rem_shift - {1'b0, cfg.block_count});
        end
        else
        begin
            rem_next = rem_shift[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        div_reg     <= pop_data.value;
                        last_reg    <= pop_data.last;
                        rem_reg     <= '0;
                        bit_cnt_reg <= '0;
                        state_reg   <= B_MOD;
                    end
                end
                B_MOD:
                begin
                    rem_reg     <= rem_next;
                    div_reg     <= div_reg << 1;
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    prod_reg  <= scaled[OFFSET_W-1:0];
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        rsp_reg   <= '{byte_offset: prod_reg, last: last_reg};
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/block_offset_generator.sv -----
// A request passes the front end, the job queue and the back end's bit-serial reduction;
// the front end first reduces the counter bit-serially when block_count shrank below it.
// New requests are taken once the last job is queued, while the back end may still be busy.
// Reset: clears all handshake state, loads the seed, zeroes the counter and restores the
// register defaults (block_count 1, block_size 4096, random mode).
module block_offset_generator #(
    parameter int unsigned QUEUE_DEPTH = bog_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  bog_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output bog_pkg::rsp_t                    rsp,
    input  logic                             cfg_we,
    input  logic [bog_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bog_pkg::CFG_W-1:0]        cfg_data
);
    import bog_pkg::*;

    logic [COUNT_W-1:0] block_count_reg;
    logic [SIZE_W-1:0]  block_size_reg;
    logic               seq_mode_reg;
    cfg_t               cfg_eff;

    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
            block_size_reg  <= BLOCK_SIZE_RST;
            seq_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                REG_BLOCK_SIZE:  block_size_reg  <= cfg_data[SIZE_W-1:0];
                REG_SEQ_MODE:    seq_mode_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg_eff.block_count     = (block_count_reg == '0) ? COUNT_W'(1) : block_count_reg;
        if (block_size_reg == '0)
        begin
            cfg_eff.block_size = SIZE_W'(1);
        end
        else if (block_size_reg > MAX_BLOCK_SIZE)
        begin
            cfg_eff.block_size = MAX_BLOCK_SIZE;
        end
        else
        begin
            cfg_eff.block_size = block_size_reg;
        end
        cfg_eff.sequential_mode = seq_mode_reg;
    end

    bog_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_eff),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bog_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bog_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_eff),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- hw/rtl/bog_checker.sv -----
// Port-level checks for the block offset generator, bound to the top level.
module bog_checker #(
    parameter int unsigned QUEUE_DEPTH = bog_pkg::QUEUE_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bog_pkg::rsp_t rsp
);
    import bog_pkg::*;

    localparam int unsigned LIMIT  = QUEUE_DEPTH + 3;
    localparam int unsigned PEND_W = $clog2(LIMIT + 2) + 1;

    logic [PEND_W-1:0] pending_reg;
    logic              req_take;
    logic              rsp_take;

    assign req_take = req_valid && req_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (req_take && !rsp_take)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (rsp_take && !req_take)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    rsp_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response word dropped before it was taken");

    rsp_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("stalled response word changed");

    rsp_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != '0)
        else $error("response word without an accepted request");

    pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(LIMIT))
        else $error("more requests in flight than the pipeline can hold");

endmodule

bind block_offset_generator bog_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_bog_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
